>>> sv/lcc_pkg.sv
// Shared constants, types and helpers for the linear cross-correlation block.
// Used by lcc_mac and linear_cross_correlation; depends on nothing else.
`default_nettype none

package lcc_pkg;

    localparam int MAX_LEN  = 32;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = 6;                  // length registers and sample counts
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int CORR_W   = 37;
    localparam int LAG_W    = 6;
    localparam int SUM_W    = LEN_W + 1;          // m + j, xlen + ylen
    localparam int REG_IDX_W = 1;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_X_LENGTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_Y_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic valid;   // operands present this cycle
    } mac_ctrl_t;

    // a length of zero acts as one, anything above MAX_LEN acts as MAX_LEN
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_LEN)) begin
            r = LEN_W'(MAX_LEN);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/lcc_mac.sv
// Shared multiply-accumulate unit: registered product, then full-width accumulate.
// Depends on lcc_pkg.
`default_nettype none

module lcc_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lcc_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [lcc_pkg::SAMPLE_W-1:0] a,
    input  wire logic signed [lcc_pkg::SAMPLE_W-1:0] b,
    output logic signed [lcc_pkg::CORR_W-1:0]        acc,
    output logic                                     busy
);
    import lcc_pkg::*;

    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CORR_W-1:0]   acc_reg;
    logic signed [CORR_W-1:0]   acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + CORR_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

`default_nettype wire

>>> sv/linear_cross_correlation.sv
// Linear cross-correlation: loads x and y sample stores, then sweeps every lag
// through one shared multiply-accumulate unit. Depends on lcc_pkg and lcc_mac.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  cfg     | cfg_valid/ready, cfg_index, cfg_data       | in
//  samples | s_valid/ready, s_req_type, s_sample        | in
//  results | m_valid/ready, m_lag_index, m_corr_value,  | out
//          | m_last                                     |
//
// A completing sample starts the lag sweep over xlen + ylen - 1 lags; each lag takes
// one product a cycle through the single multiplier, a drain of the
// read/product/accumulate pipe and one emit step.
// s_ready is low for the whole sweep; a stalled m_ready holds the sweep at the emit step.
// Synchronous active-low reset clears counts, lengths (to 32) and the sequencer;
// sample stores are not cleared.
`default_nettype none

module linear_cross_correlation (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lcc_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [lcc_pkg::LEN_W-1:0]            cfg_data,
    // samples in
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_req_type,
    input  wire logic signed [lcc_pkg::SAMPLE_W-1:0]  s_sample,
    // results out
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [lcc_pkg::LAG_W-1:0]                 m_lag_index,
    output logic signed [lcc_pkg::CORR_W-1:0]         m_corr_value,
    output logic                                      m_last
);
    import lcc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] x_len_reg, y_len_reg;
    logic [LEN_W-1:0] x_count_reg, x_count_next;
    logic [LEN_W-1:0] y_count_reg, y_count_next;
    logic [LEN_W-1:0] m_reg, m_next;
    logic [LAG_W-1:0] j_reg, j_next;

    logic [LEN_W-1:0] xl, yl;
    logic [SUM_W-1:0] lag_last;
    logic             s_accept, store_x, store_y, complete;

    // sample stores
    logic signed [SAMPLE_W-1:0] x_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] y_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] x_rd_reg, y_rd_reg;
    logic                       rd_valid_reg, rd_mask_reg;

    logic [SUM_W-1:0]  t_sum, x_idx;
    logic              in_range, issue;

    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] mac_a;
    logic signed [CORR_W-1:0]   mac_acc;
    logic                       mac_busy;

    logic                       out_load;
    logic                       m_valid_reg;
    logic [LAG_W-1:0]           lag_reg;
    logic signed [CORR_W-1:0]   corr_reg;
    logic                       last_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    assign xl       = eff_len(x_len_reg);
    assign yl       = eff_len(y_len_reg);
    assign lag_last = SUM_W'(xl) + SUM_W'(yl) - SUM_W'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_len_reg <= LEN_RESET;
            y_len_reg <= LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_X_LENGTH: x_len_reg <= cfg_data;
                REG_Y_LENGTH: y_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // load side: append, then check for completion against the updated counts
    always_comb begin
        store_x      = s_accept && !s_req_type && (x_count_reg < xl);
        store_y      = s_accept &&  s_req_type && (y_count_reg < yl);
        x_count_next = x_count_reg + LEN_W'(store_x);
        y_count_next = y_count_reg + LEN_W'(store_y);
        complete     = s_accept && (x_count_next >= xl) && (y_count_next >= yl);
        if (complete) begin
            x_count_next = '0;
            y_count_next = '0;
        end
    end

    // x index for the current (j, m): m + j - (ylen - 1); x is taken as zero outside 0..xlen-1
    always_comb begin
        t_sum    = SUM_W'(m_reg) + SUM_W'(j_reg);
        x_idx    = t_sum - SUM_W'(yl - LEN_W'(1));
        in_range = (t_sum >= SUM_W'(yl - LEN_W'(1))) && (x_idx < SUM_W'(xl));
        issue    = (state_reg == ST_ISSUE);
    end

    always_ff @(posedge aclk) begin
        if (store_x) begin
            x_mem[x_count_reg[ADDR_W-1:0]] <= s_sample;
        end
        x_rd_reg <= x_mem[x_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (store_y) begin
            y_mem[y_count_reg[ADDR_W-1:0]] <= s_sample;
        end
        y_rd_reg <= y_mem[m_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            rd_mask_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            rd_mask_reg  <= issue && in_range;
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // sequencer over lags j and products m
    always_comb begin
        state_next     = state_reg;
        m_next         = m_reg;
        j_next         = j_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = rd_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (complete) begin
                    j_next         = '0;
                    m_next         = '0;
                    mac_ctrl.clear = 1'b1;
                    state_next     = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                m_next = m_reg + LEN_W'(1);
                if (m_reg == yl - LEN_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !mac_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (SUM_W'(j_reg) == lag_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next         = j_reg + LAG_W'(1);
                        m_next         = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            x_count_reg <= '0;
            y_count_reg <= '0;
            m_reg       <= '0;
            j_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            x_count_reg <= x_count_next;
            y_count_reg <= y_count_next;
            m_reg       <= m_next;
            j_reg       <= j_next;
        end
    end

    assign mac_a = rd_mask_reg ? x_rd_reg : '0;

    lcc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a       (mac_a),
        .b       (y_rd_reg),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lag_reg  <= j_reg;
            corr_reg <= mac_acc;
            last_reg <= (SUM_W'(j_reg) == lag_last);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lag_index  = lag_reg;
    assign m_corr_value = corr_reg;
    assign m_last       = last_reg;

    // the pipe must be empty before a sum is taken
    a_drained_at_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!rd_valid_reg && !mac_busy))
        else $error("emit with products still in flight");

    // reads only follow issue cycles
    a_read_from_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(state_reg == ST_ISSUE))
        else $error("read stage loaded outside issue");

    // product index stays inside the y sequence
    a_m_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (m_reg < yl))
        else $error("product index past y length");

    // no new sample transaction while a sweep is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("sample accepted during sweep");

endmodule

`default_nettype wire
